// File: hdl/scpc_pkg.sv
package scpc_pkg;

    // Field widths
    localparam int RANGE_W = 16;
    localparam int BEAM_W  = 12;
    localparam int ANGLE_W = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int OUT_W   = 17;

    // Datapath widths: x/y in Q16 with headroom for CORDIC gain, z in 2pi/2^32 units
    localparam int XY_W = 36;
    localparam int Z_W  = 34;

    // 1/K in Q32
    localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;
    localparam int          OUT_LIMIT    = 65535;

    // Parameter defaults
    localparam int DEF_BEAM_COUNT      = 4096;
    localparam int DEF_ROTATION_STAGES = 16;
    localparam int MAX_STAGES          = 24;

    // atan(2^-i) in units of 2pi/2^32
    localparam logic [31:0] ATAN_TABLE [0:MAX_STAGES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_MIN_RANGE   = 3'd0,
        CFG_MAX_RANGE   = 3'd1,
        CFG_START_ANGLE = 3'd2,
        CFG_ANGLE_STEP  = 3'd3
    } t_cfg_idx;

    // One beat in flight through the rotation stages
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [BEAM_W-1:0]      beam;
    } t_pipe;

endpackage

// File: hdl/scan_polar_to_cartesian_top.sv
// Scanner polar-to-Cartesian converter. Each beat on the input carries one range
// sample and its beam number; samples outside [min_range, max_range] or with a
// beam number not below BEAM_COUNT are dropped. Kept samples are rotated to
// start_angle + beam_number * angle_step (binary angle, 2pi/65536 per unit) by a
// fully pipelined rotation-mode CORDIC and leave as x/y in mm with the beam
// number. One sample is taken every clock cycle while o_ready is high; results
// pass through registers for range scaling and angle multiply, quadrant fold,
// one per rotation stage and output rounding, with at most 24 rotation stages
// used. An output register and one skid entry decouple the sides; o_ready drops
// only when both hold results, which stalls the whole pipe. Registers must be
// written while the block is idle.
module scan_polar_to_cartesian_top #(
    parameter int BEAM_COUNT      = scpc_pkg::DEF_BEAM_COUNT,
    parameter int ROTATION_STAGES = scpc_pkg::DEF_ROTATION_STAGES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [scpc_pkg::RANGE_W-1:0]      i_range_mm,
    input  logic [scpc_pkg::BEAM_W-1:0]       i_beam_number,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [scpc_pkg::OUT_W-1:0] o_point_x,
    output logic signed [scpc_pkg::OUT_W-1:0] o_point_y,
    output logic [scpc_pkg::BEAM_W-1:0]       o_point_beam,
    input  logic                              i_cfg_we,
    input  logic [scpc_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [scpc_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int NUM_ST = (ROTATION_STAGES < scpc_pkg::MAX_STAGES) ?
                            ROTATION_STAGES : scpc_pkg::MAX_STAGES;

    logic            en;
    logic            pipe_valid [0:NUM_ST];
    scpc_pkg::t_pipe pipe_data  [0:NUM_ST];

    assign o_ready = en;

    // Range window, angle and start vector
    scpc_front #(
        .BEAM_COUNT (BEAM_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_valid),
        .i_range_mm    (i_range_mm),
        .i_beam_number (i_beam_number),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (pipe_valid[0]),
        .o_data        (pipe_data[0])
    );

    // Rotation stages, one register each
    for (genvar k = 0; k < NUM_ST; k++) begin : g_stage
        scpc_cordic_stage #(
            .STAGE (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (pipe_valid[k]),
            .i_data  (pipe_data[k]),
            .o_valid (pipe_valid[k+1]),
            .o_data  (pipe_data[k+1])
        );
    end

    // Rounding, clamping and output buffering
    scpc_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (pipe_valid[NUM_ST]),
        .i_data       (pipe_data[NUM_ST]),
        .i_ready      (i_ready),
        .o_en         (en),
        .o_valid      (o_valid),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_point_beam (o_point_beam)
    );

endmodule

// File: hdl/scpc_front.sv
module scpc_front #(
    parameter int BEAM_COUNT = scpc_pkg::DEF_BEAM_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [scpc_pkg::RANGE_W-1:0]  i_range_mm,
    input  logic [scpc_pkg::BEAM_W-1:0]   i_beam_number,
    input  logic                          i_cfg_we,
    input  logic [scpc_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [scpc_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output scpc_pkg::t_pipe               o_data
);

    localparam int BC_W = 17;

    // Configuration registers
    logic [scpc_pkg::CFG_W-1:0]   r_min_range;
    logic [scpc_pkg::CFG_W-1:0]   r_max_range;
    logic [scpc_pkg::ANGLE_W-1:0] r_start_angle;
    logic [scpc_pkg::ANGLE_W-1:0] r_angle_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range   <= '0;
            r_max_range   <= '1;
            r_start_angle <= '0;
            r_angle_step  <= '0;
        end else if (i_cfg_we) begin
            unique case (scpc_pkg::t_cfg_idx'(i_cfg_index))
                scpc_pkg::CFG_MIN_RANGE:   r_min_range   <= i_cfg_data;
                scpc_pkg::CFG_MAX_RANGE:   r_max_range   <= i_cfg_data;
                scpc_pkg::CFG_START_ANGLE: r_start_angle <= i_cfg_data;
                scpc_pkg::CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage A: window check, beam angle, gain-compensated range
    logic        keep;
    logic [47:0] x_prod;
    logic [47:0] x_round;
    logic [27:0] ang_prod;
    logic [scpc_pkg::ANGLE_W-1:0] n_a_ang;

    assign keep = (i_range_mm >= r_min_range) && (i_range_mm <= r_max_range) &&
                  ({{(BC_W-scpc_pkg::BEAM_W){1'b0}}, i_beam_number} < BC_W'(BEAM_COUNT));
    assign x_prod   = 48'(i_range_mm) * 48'(scpc_pkg::INV_GAIN_Q32);
    assign x_round  = x_prod + 48'd32768;
    assign ang_prod = 28'(i_beam_number) * 28'(r_angle_step);
    assign n_a_ang  = r_start_angle + ang_prod[scpc_pkg::ANGLE_W-1:0];

    logic                         r_a_valid;
    logic [31:0]                  r_a_x0;
    logic [scpc_pkg::ANGLE_W-1:0] r_a_ang;
    logic [scpc_pkg::BEAM_W-1:0]  r_a_beam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x0   <= x_round[47:16];
            r_a_ang  <= n_a_ang;
            r_a_beam <= i_beam_number;
        end
    end

    // Stage B: fold into the right half plane, build the start vector
    logic                         flip;
    logic [scpc_pkg::ANGLE_W-1:0] ang_fold;
    logic [scpc_pkg::ANGLE_W-1:0] ang_bias;
    logic signed [scpc_pkg::XY_W-1:0] x_start;
    scpc_pkg::t_pipe n_b_data;

    assign ang_bias = r_a_ang + 16'h4000;
    assign flip     = ang_bias[15];
    assign ang_fold = flip ? (r_a_ang - 16'h8000) : r_a_ang;
    assign x_start  = signed'({{(scpc_pkg::XY_W-32){1'b0}}, r_a_x0});

    always_comb begin
        n_b_data.x    = flip ? -x_start : x_start;
        n_b_data.y    = '0;
        n_b_data.z    = signed'({{(scpc_pkg::Z_W-32){ang_fold[15]}}, ang_fold, 16'h0000});
        n_b_data.beam = r_a_beam;
    end

    logic            r_b_valid;
    scpc_pkg::t_pipe r_b_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_data <= n_b_data;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

// File: hdl/scpc_cordic_stage.sv
module scpc_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  scpc_pkg::t_pipe i_data,
    output logic            o_valid,
    output scpc_pkg::t_pipe o_data
);

    // One micro-rotation: direction from the sign of the residual angle
    logic signed [scpc_pkg::XY_W-1:0] xs;
    logic signed [scpc_pkg::XY_W-1:0] ys;
    logic signed [scpc_pkg::Z_W-1:0]  step;
    scpc_pkg::t_pipe n_data;

    assign xs   = i_data.x >>> STAGE;
    assign ys   = i_data.y >>> STAGE;
    assign step = signed'({{(scpc_pkg::Z_W-32){1'b0}}, scpc_pkg::ATAN_TABLE[STAGE]});

    always_comb begin
        n_data.beam = i_data.beam;
        if (!i_data.z[scpc_pkg::Z_W-1]) begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - step;
        end else begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + step;
        end
    end

    logic            r_valid;
    scpc_pkg::t_pipe r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: hdl/scpc_out.sv
module scpc_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  scpc_pkg::t_pipe                   i_data,
    input  logic                              i_ready,
    output logic                              o_en,
    output logic                              o_valid,
    output logic signed [scpc_pkg::OUT_W-1:0] o_point_x,
    output logic signed [scpc_pkg::OUT_W-1:0] o_point_y,
    output logic [scpc_pkg::BEAM_W-1:0]       o_point_beam
);

    // Round Q16 to mm and clamp to the symmetric output range
    function automatic logic signed [scpc_pkg::OUT_W-1:0] finish(
        input logic signed [scpc_pkg::XY_W-1:0] v
    );
        logic signed [scpc_pkg::XY_W-1:0] sum;
        logic signed [scpc_pkg::XY_W-17:0] mm;
        logic signed [scpc_pkg::OUT_W-1:0] res;
        sum = v + scpc_pkg::XY_W'(32768);
        mm  = sum[scpc_pkg::XY_W-1:16];
        if (mm > (scpc_pkg::XY_W-16)'(scpc_pkg::OUT_LIMIT)) begin
            res = scpc_pkg::OUT_W'(scpc_pkg::OUT_LIMIT);
        end else if (mm < -((scpc_pkg::XY_W-16)'(scpc_pkg::OUT_LIMIT))) begin
            res = -(scpc_pkg::OUT_W'(scpc_pkg::OUT_LIMIT));
        end else begin
            res = mm[scpc_pkg::OUT_W-1:0];
        end
        return res;
    endfunction

    logic signed [scpc_pkg::OUT_W-1:0] fin_x;
    logic signed [scpc_pkg::OUT_W-1:0] fin_y;

    assign fin_x = finish(i_data.x);
    assign fin_y = finish(i_data.y);

    // Output register plus one skid entry; the pipe runs while the skid is empty
    logic                              r_out_valid;
    logic signed [scpc_pkg::OUT_W-1:0] r_out_x;
    logic signed [scpc_pkg::OUT_W-1:0] r_out_y;
    logic [scpc_pkg::BEAM_W-1:0]       r_out_beam;
    logic                              r_skid_valid;
    logic signed [scpc_pkg::OUT_W-1:0] r_skid_x;
    logic signed [scpc_pkg::OUT_W-1:0] r_skid_y;
    logic [scpc_pkg::BEAM_W-1:0]       r_skid_beam;
    logic                              out_free;

    assign o_en     = !r_skid_valid;
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_valid;
            end
        end else if (!r_skid_valid && i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_x    <= r_skid_x;
                r_out_y    <= r_skid_y;
                r_out_beam <= r_skid_beam;
            end else begin
                r_out_x    <= fin_x;
                r_out_y    <= fin_y;
                r_out_beam <= i_data.beam;
            end
        end else if (!r_skid_valid) begin
            r_skid_x    <= fin_x;
            r_skid_y    <= fin_y;
            r_skid_beam <= i_data.beam;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_point_x    = r_out_x;
    assign o_point_y    = r_out_y;
    assign o_point_beam = r_out_beam;

endmodule

// File: hdl/scpc_checker.sv
module scpc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic signed [scpc_pkg::OUT_W-1:0] o_point_x,
    input logic signed [scpc_pkg::OUT_W-1:0] o_point_y,
    input logic [scpc_pkg::BEAM_W-1:0]       o_point_beam
);

    localparam logic [scpc_pkg::OUT_W-1:0] MOST_NEG = {1'b1, {(scpc_pkg::OUT_W-1){1'b0}}};

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_point_x) &&
        $stable(o_point_y) && $stable(o_point_beam))
        else $error("result beat changed while stalled");

    // Clamp never lets the most negative code through
    a_out_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_point_x != MOST_NEG) && (o_point_y != MOST_NEG))
        else $error("coordinate outside clamp range");

    // Input back-pressure only while a result is waiting
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output not empty after reset");

endmodule

bind scan_polar_to_cartesian_top scpc_checker u_scpc_checker (.*);

// File: tb/scpc_tb_pkg.sv
package scpc_tb_pkg;

    import scpc_pkg::*;

    localparam int TB_BEAM_COUNT = DEF_BEAM_COUNT;
    localparam int TB_STAGES     = DEF_ROTATION_STAGES;
    // the datapath never applies more than 24 rotations
    localparam int STAGES_USED   = (TB_STAGES < 24) ? TB_STAGES : 24;
    localparam longint unsigned INV_GAIN = 64'h9B74EDA8;
    localparam longint OUT_SAT = 65535;
    localparam int MAX_REPORTS = 10;

    // atan(2^-i) in 2pi/2^32 units
    localparam longint ROT_ANGLE [0:23] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [BEAM_W-1:0]       beam;
    } t_point;

    class point_scoreboard;
        logic [CFG_W-1:0] min_range_q;
        logic [CFG_W-1:0] max_range_q;
        logic [CFG_W-1:0] start_angle_q;
        logic [CFG_W-1:0] angle_step_q;
        t_point expected_points[$];
        int unsigned kept_count;
        int unsigned mismatches;

        function new();
            min_range_q   = '0;
            max_range_q   = '1;
            start_angle_q = '0;
            angle_step_q  = '0;
            kept_count    = 0;
            mismatches    = 0;
        endfunction

        // mirror of a register write; spare indexes do nothing
        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MIN_RANGE:   min_range_q   = val;
                CFG_MAX_RANGE:   max_range_q   = val;
                CFG_START_ANGLE: start_angle_q = val;
                CFG_ANGLE_STEP:  angle_step_q  = val;
                default: ;
            endcase
        endfunction

        // Q16 to mm: round half up, clamp to the 17-bit output range
        function logic [OUT_W-1:0] round_sat(longint q);
            longint v;
            v = (q + 64'sd32768) >>> 16;
            if (v > OUT_SAT)
                v = OUT_SAT;
            if (v < -OUT_SAT)
                v = -OUT_SAT;
            return v[OUT_W-1:0];
        endfunction

        // range and beam gates, beam angle, quadrant fold, then the rotation stages
        function bit cartesian_point(logic [RANGE_W-1:0] r, logic [BEAM_W-1:0] b,
                                     output t_point p);
            int unsigned ang;
            logic [15:0] a;
            logic [15:0] t;
            longint unsigned x0;
            longint x, y, z, xs, ys;
            p = '0;
            if (r < min_range_q || r > max_range_q)
                return 0;
            if (int'(b) >= TB_BEAM_COUNT)
                return 0;
            ang = int'(start_angle_q) + int'(b) * int'(angle_step_q);
            a = ang[15:0];
            x0 = (longint'(r) * INV_GAIN + 64'd32768) >> 16;
            x = longint'(x0);
            y = 0;
            t = a + 16'h4000;
            if (t[15]) begin
                x = -x;
                a = a - 16'h8000;
            end
            z = longint'($signed(a)) * 65536;
            for (int i = 0; i < STAGES_USED; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ROT_ANGLE[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ROT_ANGLE[i];
                end
            end
            p.x = round_sat(x);
            p.y = round_sat(y);
            p.beam = b;
            return 1;
        endfunction

        // accepted input beat
        function void note_sample(logic [RANGE_W-1:0] r, logic [BEAM_W-1:0] b);
            t_point p;
            if (cartesian_point(r, b, p)) begin
                expected_points = {expected_points, p};
                kept_count++;
            end
        endfunction

        // accepted output beat against the oldest expected point
        function void check_point(logic [OUT_W-1:0] x, logic [OUT_W-1:0] y,
                                  logic [BEAM_W-1:0] b);
            t_point p;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected point: x=%0d y=%0d beam=%0d",
                             $signed(x), $signed(y), b);
                return;
            end
            p = expected_points.pop_front();
            if (p.x !== x || p.y !== y || p.beam !== b) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"point mismatch: expected x=%0d y=%0d beam=%0d,",
                              " got x=%0d y=%0d beam=%0d"},
                             p.x, p.y, p.beam, $signed(x), $signed(y), b);
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

endpackage

// File: tb/tb_top.sv
module tb_top;

    import scpc_pkg::*;
    import scpc_tb_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int CLK_PERIOD     = 2 * CLK_HALF;
    localparam int RESET_CYCLES   = 7;
    localparam int LATENCY        = TB_STAGES + 3;
    localparam int DRAIN_CYCLES   = 2 * LATENCY + 8;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int PHASES         = 8;
    localparam int PHASE_POINTS   = 120;
    localparam int HOLD_CYCLES    = 300;
    localparam logic [IDX_W-1:0] FIRST_SPARE_IDX = 3'd4;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_valid       = 1'b0;
    logic                    o_ready;
    logic [RANGE_W-1:0]      i_range_mm    = '0;
    logic [BEAM_W-1:0]       i_beam_number = '0;
    logic                    o_valid;
    logic                    i_ready       = 1'b0;
    logic signed [OUT_W-1:0] o_point_x;
    logic signed [OUT_W-1:0] o_point_y;
    logic [BEAM_W-1:0]       o_point_beam;
    logic                    i_cfg_we      = 1'b0;
    logic [IDX_W-1:0]        i_cfg_index   = '0;
    logic [CFG_W-1:0]        i_cfg_data    = '0;

    point_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    scan_polar_to_cartesian_top #(
        .BEAM_COUNT      (TB_BEAM_COUNT),
        .ROTATION_STAGES (TB_STAGES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_range_mm    (i_range_mm),
        .i_beam_number (i_beam_number),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_beam  (o_point_beam),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // receiver: random stalls, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // beat monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_sample(i_range_mm, i_beam_number);
            if (o_valid && i_ready)
                sb.check_point(o_point_x, o_point_y, o_point_beam);
        end
    end

    task automatic set_idle(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default:   begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                            logic [CFG_W-1:0] start, logic [CFG_W-1:0] step);
        write_reg(CFG_MIN_RANGE, lo);
        write_reg(CFG_MAX_RANGE, hi);
        write_reg(CFG_START_ANGLE, start);
        write_reg(CFG_ANGLE_STEP, step);
    endtask

    // offer one sample beat, optional idle cycles first
    task automatic send_sample(logic [RANGE_W-1:0] r, logic [BEAM_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_range_mm    <= r;
        i_beam_number <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // stop offering, wait for every expected point, then let dropped beats flush
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly in-window ranges, some window edges, some anything
    function automatic logic [RANGE_W-1:0] pick_range();
        logic [RANGE_W-1:0] r;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(5))
                    0: r = sb.min_range_q;
                    1: r = sb.max_range_q;
                    2: r = sb.min_range_q - 1'b1;
                    3: r = sb.max_range_q + 1'b1;
                    4: r = '0;
                    default: r = '1;
                endcase
            end
            1: r = RANGE_W'($urandom_range(65535));
            default: r = RANGE_W'($urandom_range(sb.max_range_q, sb.min_range_q));
        endcase
        return r;
    endfunction

    function automatic logic [BEAM_W-1:0] pick_beam();
        logic [BEAM_W-1:0] b;
        if ($urandom_range(9) == 0)
            b = $urandom_range(1) ? '1 : '0;
        else
            b = BEAM_W'($urandom_range(4095));
        return b;
    endfunction

    // window, start and step for one random phase, extremes in the first two
    task automatic random_regs(int ph);
        logic [CFG_W-1:0] lo, hi, tmp, start, step;
        case (ph)
            0: set_regs(16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF);
            1: set_regs(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0001);
            default: begin
                if (ph % 2 == 0) begin
                    lo = CFG_W'($urandom_range(2000));
                    hi = CFG_W'($urandom_range(65535, 60000));
                end else begin
                    lo = CFG_W'($urandom_range(65535));
                    tmp = CFG_W'($urandom_range(3000));
                    hi = (int'(lo) + int'(tmp) > 65535) ? 16'hFFFF : lo + tmp;
                end
                if (lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                start = CFG_W'($urandom_range(65535));
                step  = $urandom_range(1) ? CFG_W'($urandom_range(64)) :
                                            CFG_W'($urandom_range(65535));
                set_regs(lo, hi, start, step);
            end
        endcase
    endtask

    initial begin
        int sent;
        int unsigned kept0;
        logic [RANGE_W-1:0] r;
        logic [BEAM_W-1:0] b;

        sb = new();
        set_idle(IDLE_NONE);
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: angle zero, range and beam extremes
        send_sample(16'd0, 12'd0);
        send_sample(16'hFFFF, 12'd0);
        send_sample(16'hFFFF, 12'hFFF);
        send_sample(16'd1, 12'd2048);
        settle();

        // quarter-turn steps land on every fold boundary
        set_regs(16'h0000, 16'hFFFF, 16'h4000, 16'h4000);
        send_sample(16'hFFFF, 12'd0);
        send_sample(16'hFFFF, 12'd1);
        send_sample(16'hFFFF, 12'd2);
        send_sample(16'hFFFF, 12'd3);
        send_sample(16'd40000, 12'hFFF);
        settle();

        // just inside the folds
        write_reg(CFG_START_ANGLE, 16'h3FFF);
        write_reg(CFG_ANGLE_STEP, 16'h8000);
        send_sample(16'hFFFF, 12'd0);
        send_sample(16'hFFFF, 12'd1);
        send_sample(16'd12345, 12'd4094);
        settle();

        // most negative start, largest step: the beam angle wraps
        write_reg(CFG_START_ANGLE, 16'h8000);
        write_reg(CFG_ANGLE_STEP, 16'hFFFF);
        send_sample(16'hFFFF, 12'd0);
        send_sample(16'hFFFF, 12'd1);
        send_sample(16'hFFFF, 12'hFFF);
        settle();

        // window edges; writes to spare indexes must change nothing
        write_reg(CFG_MIN_RANGE, 16'd100);
        for (int k = FIRST_SPARE_IDX; k < (1 << IDX_W); k++)
            write_reg(k[IDX_W-1:0], 16'hFFFF);
        write_reg(CFG_MAX_RANGE, 16'd200);
        send_sample(16'd99, pick_beam());
        send_sample(16'd100, pick_beam());
        send_sample(16'd200, pick_beam());
        send_sample(16'd201, pick_beam());
        settle();

        // empty window drops everything
        write_reg(CFG_MIN_RANGE, 16'd500);
        write_reg(CFG_MAX_RANGE, 16'd400);
        send_sample(16'd450, 12'd7);
        send_sample(16'd0, 12'd8);
        send_sample(16'hFFFF, 12'd9);
        settle();

        // single-value window
        write_reg(CFG_MIN_RANGE, 16'd777);
        write_reg(CFG_MAX_RANGE, 16'd777);
        send_sample(16'd776, 12'd10);
        send_sample(16'd777, 12'd11);
        send_sample(16'd778, 12'd12);
        settle();

        // random phases, idling pattern rotates per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            random_regs(ph);
            set_idle(t_idle_mode'(ph % 4));
            kept0 = sb.kept_count;
            sent = 0;
            while (sb.kept_count - kept0 < PHASE_POINTS) begin
                // long receiver hold-off while samples keep coming
                if (ph == 0 && sent == 20)
                    hold_left = HOLD_CYCLES;
                // sender pause until the pipe is empty
                if (ph == 6 && sent == 60)
                    settle();
                r = pick_range();
                b = pick_beam();
                send_sample(r, b);
                sent++;
            end
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/scpc_pkg.sv
hdl/scpc_front.sv
hdl/scpc_cordic_stage.sv
hdl/scpc_out.sv
hdl/scan_polar_to_cartesian_top.sv
hdl/scpc_checker.sv
tb/scpc_tb_pkg.sv
tb/tb_top.sv
